### hdl/sysres_pkg.sv
// ----------------------------------------------------------------------------
// sysres_pkg
// Types and constants shared by the systematic resampler.
// ----------------------------------------------------------------------------
package sysres_pkg;

   localparam int MAX_PARTICLES_DEF = 4096;
   localparam int WEIGHT_BITS_DEF   = 24;
   localparam int CFG_W             = 13;
   localparam int COUNT_RESET       = 1024;
   localparam int IN_WEIGHT_W       = 24;
   localparam int INDEX_W           = 12;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [IN_WEIGHT_W-1:0]    particle_weight;
      logic signed [31:0]        particle_value;
      logic [IN_WEIGHT_W-1:0]    uniform_offset;
   } req_type;

   typedef struct packed {
      logic signed [31:0]        chosen_value;
      logic [INDEX_W-1:0]        chosen_index;
      logic                      last_output;
      logic                      status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULA,
      ST_MULB,
      ST_READ,
      ST_MUL,
      ST_CMP
   } state_type;

endpackage

### hdl/systematic_resampler_core.sv
// ----------------------------------------------------------------------------
// systematic_resampler_core
// Systematic particle resampler with cumulative weight and value memories.
// ----------------------------------------------------------------------------
// Usage:
//   Write the particle count on the csr_ channel while the block is idle and
//   start is low; the write starts a new round. Present a request with start
//   while busy is low.
//   A load (func 0) stores the particle value and the running cumulative
//   weight and never produces a response. Loads beyond the count are
//   dropped.
//   A fetch (func 1) produces one response, shown for one cycle with
//   rsp_strobe. An early fetch (round not fully loaded, or zero total weight)
//   answers with status 1 in the next cycle and leaves busy low.
//   A valid fetch walks the cumulative memory from the stored walk pointer:
//   each step is a memory read, a count multiply and a compare. The first
//   fetch of a round begins with the offset multiply (states MULA, MULB).
//   Over a round the walk pointer advances at most count - 1 times.
//   The receiver cannot stall; responses are never held back.
//   Synchronous reset clears the round and sets the count to 1024 (or
//   MAX_PARTICLES if smaller); the memories are not cleared and need none,
//   since a fetch reads only entries loaded in the current round.
// ----------------------------------------------------------------------------
module systematic_resampler_core
   import sysres_pkg::*;
#(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
   parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int IW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W = IW + 1;
   localparam int CW    = IW + WEIGHT_BITS;
   localparam int TW    = CW + IW + 1;
   localparam int HALF  = (CW + 1) / 2;
   localparam int PW    = IN_WEIGHT_W + CW;
   localparam int RESET_COUNT =
      (COUNT_RESET > MAX_PARTICLES) ? MAX_PARTICLES : COUNT_RESET;
   localparam logic [IN_WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= IN_WEIGHT_W) ?
      {IN_WEIGHT_W{1'b1}} : IN_WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

   logic [CW-1:0] cum_mem [MAX_PARTICLES];
   logic [31:0]   val_mem [MAX_PARTICLES];

   state_type            phase_ff, phase_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic [CNT_W-1:0]     emitted_ff, emitted_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [IW-1:0]        walk_ff, walk_in;
   logic [IN_WEIGHT_W-1:0] offset_ff, offset_in;
   logic [TW-1:0]        thr_ff, thr_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [TW-1:0]        prod_ff, prod_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [CW-1:0]        cum_rd_ff;
   logic [31:0]          val_rd_ff;
   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [CW-1:0]        cum_wdata;
   logic [31:0]          val_wdata;
   logic                 mem_re;

   logic [31:0]          cfg_raw;
   logic [31:0]          cfg_eff;
   logic [IW-1:0]        last_idx;
   logic [CW-1:0]        weight_ext;
   logic [CNT_W-1:0]     emitted_next;
   logic [PW-1:0]        hi_prod;

   assign busy       = (phase_ff != ST_IDLE);
   assign csr_ready  = (phase_ff == ST_IDLE) && !start;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign cfg_raw    = 32'(csr_data);
   assign cfg_eff    = (cfg_raw == 32'd0) ? 32'd1 :
                       (cfg_raw > 32'(MAX_PARTICLES)) ? 32'(MAX_PARTICLES) : cfg_raw;
   assign last_idx   = IW'(count_ff - CNT_W'(1));
   assign weight_ext = CW'(req_data.particle_weight & WMASK);
   assign emitted_next = emitted_ff + CNT_W'(1);
   assign hi_prod    = PW'(offset_ff) * PW'(total_ff[CW-1:HALF]);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      loaded_in     = loaded_ff;
      emitted_in    = emitted_ff;
      total_in      = total_ff;
      walk_in       = walk_ff;
      offset_in     = offset_ff;
      thr_in        = thr_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = loaded_ff[IW-1:0];
      cum_wdata     = total_ff + weight_ext;
      val_wdata     = req_data.particle_value;
      mem_re        = 1'b0;

      case (phase_ff)
         ST_IDLE: begin
            if (csr_valid && !start) begin
               count_in   = CNT_W'(cfg_eff);
               loaded_in  = '0;
               total_in   = '0;
               walk_in    = '0;
               emitted_in = '0;
            end else if (start) begin
               if (req_data.func == FUNC_LOAD) begin
                  if (loaded_ff < count_ff) begin
                     mem_we    = 1'b1;
                     total_in  = total_ff + weight_ext;
                     loaded_in = loaded_ff + CNT_W'(1);
                  end
               end else if (loaded_ff < count_ff || total_ff == '0) begin
                  rsp_strobe_in            = 1'b1;
                  rsp_data_in.chosen_value = '0;
                  rsp_data_in.chosen_index = '0;
                  rsp_data_in.last_output  = 1'b0;
                  rsp_data_in.status       = STATUS_ERR;
               end else if (emitted_ff == '0) begin
                  offset_in = req_data.uniform_offset & WMASK;
                  walk_in   = '0;
                  phase_in  = ST_MULA;
               end else begin
                  phase_in = ST_READ;
               end
            end
         end
         ST_MULA: begin
            acc_in   = PW'(offset_ff) * PW'(total_ff[HALF-1:0]);
            phase_in = ST_MULB;
         end
         ST_MULB: begin
            thr_in   = TW'((acc_ff + (hi_prod << HALF)) >> WEIGHT_BITS);
            phase_in = ST_READ;
         end
         ST_READ: begin
            mem_re   = 1'b1;
            phase_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = TW'(cum_rd_ff) * TW'(count_ff);
            phase_in = ST_CMP;
         end
         ST_CMP: begin
            if (walk_ff < last_idx && prod_ff <= thr_ff) begin
               walk_in  = walk_ff + IW'(1);
               phase_in = ST_READ;
            end else begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.chosen_value = val_rd_ff;
               rsp_data_in.chosen_index = INDEX_W'(walk_ff);
               rsp_data_in.last_output  = (emitted_next >= count_ff);
               rsp_data_in.status       = STATUS_OK;
               emitted_in = emitted_next;
               thr_in     = thr_ff + TW'(total_ff);
               phase_in   = ST_IDLE;
               if (emitted_next >= count_ff) begin
                  loaded_in  = '0;
                  total_in   = '0;
                  walk_in    = '0;
                  emitted_in = '0;
               end
            end
         end
         default: begin
            phase_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ST_IDLE;
         count_ff      <= CNT_W'(RESET_COUNT);
         loaded_ff     <= '0;
         emitted_ff    <= '0;
         total_ff      <= '0;
         walk_ff       <= '0;
         offset_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         loaded_ff     <= loaded_in;
         emitted_ff    <= emitted_in;
         total_ff      <= total_in;
         walk_ff       <= walk_in;
         offset_ff     <= offset_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff      <= thr_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cum_mem[mem_waddr] <= cum_wdata;
         val_mem[mem_waddr] <= val_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         cum_rd_ff <= cum_mem[walk_ff];
         val_rd_ff <= val_mem[walk_ff];
      end
   end

endmodule

### tb/sv/tb_systematic_resampler_core.sv
// ----------------------------------------------------------------------------
// tb_systematic_resampler_core
// Self-checking bench for the systematic resampler. A directed table covers
// reset state, count extremes, dropped loads and error fetches. Random rounds
// of loads and fetches follow. Each response is compared against the table's
// answer where a row gives one, else an in-bench cumulative-weight predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_systematic_resampler_core;
   import sysres_pkg::*;

   localparam int RANDOM_ITEMS = 500;

   typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [CFG_W-1:0]   csr_value;
      req_type            item;
      logic               has_answer;
      rsp_type            answer;
   } plan_row_type;

   localparam int PLAN_LEN = 26;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'hFFFFFF},
         1'b1, '{32'sh0, 12'd0, 1'b0, STATUS_ERR}},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'hFFFFFF, 32'sh7FFFFFFF, 24'h0}, 1'b0, '0},
      '{ROW_CFG, 13'd0, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'h0, 32'sh80000000, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h0},
         1'b1, '{32'sh0, 12'd0, 1'b0, STATUS_ERR}},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'hFFFFFF, 32'sh1, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h800000},
         1'b1, '{32'sh0, 12'd0, 1'b0, STATUS_ERR}},
      '{ROW_CFG, 13'd1, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'hFFFFFF, 32'sh80000000, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'hFFFFFF},
         1'b1, '{32'sh80000000, 12'd0, 1'b1, STATUS_OK}},
      '{ROW_CFG, 13'd3, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'h1, 32'sh11110000, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'h0, 32'sh22220000, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'hFFFFFF, 32'shFFFFFFFF, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h555555}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'hAAAAAA}, 1'b0, '0},
      '{ROW_CFG, 13'd8191, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'h5, 32'sh0000FFFF, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h0},
         1'b1, '{32'sh0, 12'd0, 1'b0, STATUS_ERR}},
      '{ROW_CFG, 13'd2, '0, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'h0, 32'sh7FFFFFFF, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_LOAD, 24'h800000, 32'sh80000001, 24'h0}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h000001}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'hFFFFFF}, 1'b0, '0},
      '{ROW_ITEM, '0, '{FUNC_FETCH, 24'h0, 32'sh0, 24'h0},
         1'b1, '{32'sh0, 12'd0, 1'b0, STATUS_ERR}}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   // predictor state
   logic [CFG_W-1:0]   count_reg = CFG_W'(COUNT_RESET);
   logic [35:0]        cum_weight [MAX_PARTICLES_DEF];
   logic signed [31:0] particle_state [MAX_PARTICLES_DEF];
   int                 loaded_n = 0;
   logic [35:0]        round_total = '0;
   int                 walk_idx = 0;
   int                 drawn_n = 0;
   logic [23:0]        held_offset = '0;

   rsp_type expected_picks [$];
   int      fail_count = 0;
   int      applied_items = 0;
   int      burst_left = 1;

   systematic_resampler_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_PARTICLES_DEF) return MAX_PARTICLES_DEF;
      return int'(count_reg);
   endfunction

   function automatic void clear_round();
      loaded_n    = 0;
      round_total = '0;
      walk_idx    = 0;
      drawn_n     = 0;
   endfunction

   task automatic resample_predict(input req_type r, output bit produced,
                                   output bit ignored, output rsp_type pick);
      int           n;
      int           k;
      logic [63:0]  x;
      logic [127:0] prod;
      logic [63:0]  thr;
      n = active_count();
      produced = 1'b0;
      ignored  = 1'b0;
      pick     = '0;
      if (r.func == FUNC_LOAD) begin
         if (loaded_n < n) begin
            round_total = round_total + 36'(r.particle_weight);
            cum_weight[loaded_n] = round_total;
            particle_state[loaded_n] = r.particle_value;
            loaded_n++;
         end else begin
            ignored = 1'b1;
         end
      end else begin
         produced = 1'b1;
         if (loaded_n < n || round_total == 0) begin
            pick.status = STATUS_ERR;
         end else begin
            if (drawn_n == 0) begin
               held_offset = r.uniform_offset;
               walk_idx = 0;
            end
            x = 64'(held_offset) + (64'(drawn_n) << WEIGHT_BITS_DEF);
            prod = 128'(x) * 128'(round_total);
            thr = 64'(prod >> WEIGHT_BITS_DEF);
            k = walk_idx;
            if (k >= n) k = n - 1;
            while (k < n - 1 && 64'(cum_weight[k]) * 64'(n) <= thr) k++;
            walk_idx = k;
            drawn_n++;
            pick.chosen_value = particle_state[k];
            pick.chosen_index = k[INDEX_W-1:0];
            pick.last_output  = (drawn_n >= n);
            pick.status       = STATUS_OK;
            if (drawn_n >= n) clear_round();
         end
      end
   endtask

   // drive one request, hold it until the transfer, then pace the next one
   task automatic send_item(input req_type r, input bit has_answer,
                            input rsp_type answer);
      bit      produced;
      bit      ignored;
      rsp_type pick;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      resample_predict(r, produced, ignored, pick);
      if (produced) expected_picks.push_back(has_answer ? answer : pick);
      if (!ignored) applied_items++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
   endtask

   task automatic write_count(input logic [CFG_W-1:0] value);
      start <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      count_reg = value;
      clear_round();
   endtask

   function automatic req_type random_req(input logic func, input bit zero_weight);
      req_type r;
      r.func = func;
      r.particle_value = $urandom;
      case ($urandom_range(0, 9))
         0:       r.uniform_offset = 24'h0;
         1:       r.uniform_offset = 24'hFFFFFF;
         default: r.uniform_offset = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: r.particle_weight = 24'h0;
         3:       r.particle_weight = 24'hFFFFFF;
         4, 5:    r.particle_weight = 24'($urandom_range(1, 255));
         default: r.particle_weight = 24'($urandom);
      endcase
      if (zero_weight) r.particle_weight = 24'h0;
      return r;
   endfunction

   task automatic play_round(input int n, input bit zero_weights, output bit cut_short);
      int fetches;
      fetches = n;
      cut_short = 1'b0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(random_req(FUNC_FETCH, 1'b0), 1'b0, '0);
         send_item(random_req(FUNC_LOAD, zero_weights), 1'b0, '0);
      end
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 2)) send_item(random_req(FUNC_LOAD, 1'b0), 1'b0, '0);
      if ($urandom_range(0, 11) == 0) begin
         fetches = $urandom_range(0, n - 1);
         cut_short = 1'b1;
      end
      for (int p = 0; p < fetches; p++) send_item(random_req(FUNC_FETCH, 1'b0), 1'b0, '0);
      if (!cut_short && $urandom_range(0, 9) == 0)
         send_item(random_req(FUNC_FETCH, 1'b0), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_picks.size() == 0) begin
            $error("response transfer with nothing expected");
            fail_count++;
         end else begin
            want = expected_picks.pop_front();
            if (rsp_data.chosen_value !== want.chosen_value) begin
               $error("chosen_value: expected %h, got %h",
                      want.chosen_value, rsp_data.chosen_value);
               fail_count++;
            end
            if (rsp_data.chosen_index !== want.chosen_index) begin
               $error("chosen_index: expected %0d, got %0d",
                      want.chosen_index, rsp_data.chosen_index);
               fail_count++;
            end
            if (rsp_data.last_output !== want.last_output) begin
               $error("last_output: expected %b, got %b",
                      want.last_output, rsp_data.last_output);
               fail_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %b, got %b", want.status, rsp_data.status);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int  pick;
      int  cnt;
      int  n;
      bit  cut;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].kind == ROW_CFG) write_count(PLAN[i].csr_value);
         else send_item(PLAN[i].item, PLAN[i].has_answer, PLAN[i].answer);
      end

      applied_items = 0;
      while (applied_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) cnt = $urandom_range(1, 8);
         else if (pick < 88) cnt = $urandom_range(9, 40);
         else if (pick < 94) cnt = 0;
         else cnt = $urandom_range(MAX_PARTICLES_DEF + 1, (1 << CFG_W) - 1);
         write_count(CFG_W'(cnt));
         if (cnt > MAX_PARTICLES_DEF) begin
            repeat ($urandom_range(1, 5)) send_item(random_req(FUNC_LOAD, 1'b0), 1'b0, '0);
            send_item(random_req(FUNC_FETCH, 1'b0), 1'b0, '0);
         end else begin
            n = (cnt == 0) ? 1 : cnt;
            repeat ($urandom_range(1, 3)) begin
               play_round(n, $urandom_range(0, 14) == 0, cut);
               if (cut) break;
            end
         end
      end

      start <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_picks.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
hdl/sysres_pkg.sv
hdl/systematic_resampler_core.sv
tb/sv/tb_systematic_resampler_core.sv
